// ===== sv/assert_macros.svh =====
// Assertion macros shared by the ventilation pressure alarm RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define VPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/vpa_pkg.sv =====
// Package for the ventilation pressure alarm: codes, types and reset values.
package vpa_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [15:0]        OK_MIN_RESET    = 16'd40000;
    localparam logic [15:0]        LOST_LVL_RESET  = 16'd20000;
    localparam logic [7:0]         DEBOUNCE_RESET  = 8'd3;
    localparam logic signed [15:0] CRIT_TEMP_RESET = 16'sd800;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_OK_MIN    = 2'd0,
        CFG_LOST_LVL  = 2'd1,
        CFG_DEBOUNCE  = 2'd2,
        CFG_CRIT_TEMP = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_SAMPLE = 3'd0,
        KIND_TEMP   = 3'd1,
        KIND_ACK    = 3'd2,
        KIND_START  = 3'd3,
        KIND_STOP   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN  = 2'd0,
        ST_OK       = 2'd1,
        ST_DEGRADED = 2'd2,
        ST_LOST     = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0]        ok_min;
        logic [15:0]        lost_lvl;
        logic [7:0]         debounce;
        logic signed [15:0] crit_temp;
    } cfg_t;

    typedef struct packed {
        status_t vent_status;
        logic    critical_phase;
        logic    alarm_on;
        logic    lost_event;
        logic    stop_experiment;
        logic    sound_alarm;
        logic    restored_event;
        logic    start_ok;
    } res_t;

endpackage

// ===== sv/vpa_stream_if.sv =====
// Handshake interfaces for the event input and result output channels.
interface vpa_item_if #(
    parameter int SAMPLE_BITS = vpa_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             kind;
    logic [SAMPLE_BITS-1:0] pressure_code;
    logic signed [15:0]     temperature;

    modport source (output valid, output kind, output pressure_code, output temperature,
                    input ready);
    modport sink   (input valid, input kind, input pressure_code, input temperature,
                    output ready);
endinterface

interface vpa_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] vent_status;
    logic       critical_phase;
    logic       alarm_on;
    logic       lost_event;
    logic       stop_experiment;
    logic       sound_alarm;
    logic       restored_event;
    logic       start_ok;

    modport source (output valid, output vent_status, output critical_phase,
                    output alarm_on, output lost_event, output stop_experiment,
                    output sound_alarm, output restored_event, output start_ok,
                    input ready);
    modport sink   (input valid, input vent_status, input critical_phase,
                    input alarm_on, input lost_event, input stop_experiment,
                    input sound_alarm, input restored_event, input start_ok,
                    output ready);
endinterface

// ===== sv/vpa_cfg_regs.sv =====
// Configuration register bank for the ventilation pressure alarm.
module vpa_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vpa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output vpa_pkg::cfg_t                      cfg
);
    import vpa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OK_MIN:    cfg_next.ok_min    = cfg_wdata[15:0];
                CFG_LOST_LVL:  cfg_next.lost_lvl  = cfg_wdata[15:0];
                CFG_DEBOUNCE:  cfg_next.debounce  = cfg_wdata[7:0];
                CFG_CRIT_TEMP: cfg_next.crit_temp = $signed(cfg_wdata[15:0]);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ok_min    <= OK_MIN_RESET;
            cfg_reg.lost_lvl  <= LOST_LVL_RESET;
            cfg_reg.debounce  <= DEBOUNCE_RESET;
            cfg_reg.crit_temp <= CRIT_TEMP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/vpa_core.sv =====
// Input register, monitor state and per-event classification logic.
module vpa_core #(
    parameter int SAMPLE_BITS = vpa_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = vpa_pkg::COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vpa_pkg::cfg_t          cfg,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [2:0]             item_kind,
    input  logic [SAMPLE_BITS-1:0] item_pressure_code,
    input  logic signed [15:0]     item_temperature,
    output logic                   res_valid,
    input  logic                   res_ready,
    output vpa_pkg::res_t          res
);
    import vpa_pkg::*;
    `include "assert_macros.svh"

    localparam int CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    // input register
    logic                   in_valid_reg;
    logic [2:0]             kind_reg;
    logic [SAMPLE_BITS-1:0] code_reg;
    logic signed [15:0]     temp_reg;

    // monitor state
    status_t               status_reg,  status_next;
    logic                  phase_reg,   phase_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;
    logic                  alarm_reg,   alarm_next;
    logic                  monitor_reg, monitor_next;

    logic                   advance;
    logic [SAMPLE_BITS-1:0] ok_thr;
    logic [SAMPLE_BITS-1:0] lost_thr;
    logic                   is_low;
    logic                   is_high;
    logic                   temp_crit;
    logic [7:0]             limit;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   reached;
    logic                   lost_ev, stop_ev, sound_ev, rest_ev, start_ok;

    assign advance    = in_valid_reg && res_ready;
    assign item_ready = !in_valid_reg || res_ready;

    assign ok_thr    = SAMPLE_BITS'(cfg.ok_min);
    assign lost_thr  = SAMPLE_BITS'(cfg.lost_lvl);
    assign is_low    = code_reg < lost_thr;
    assign is_high   = code_reg >= ok_thr;
    assign temp_crit = temp_reg >= cfg.crit_temp;
    assign limit     = (cfg.debounce == 8'd0) ? 8'd1 : cfg.debounce;
    assign count_inc = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;
    assign reached   = CMP_BITS'(count_inc) >= CMP_BITS'(limit);

    always_comb
    begin
        status_next  = status_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        alarm_next   = alarm_reg;
        monitor_next = monitor_reg;
        lost_ev      = 1'b0;
        stop_ev      = 1'b0;
        sound_ev     = 1'b0;
        rest_ev      = 1'b0;
        start_ok     = 1'b0;
        unique case (kind_t'(kind_reg))
            KIND_SAMPLE:
            begin
                start_ok = !is_low && is_high;
                if (monitor_reg)
                begin
                    // low wins over high when the thresholds are crossed
                    if (is_low || (!is_high && status_reg == ST_LOST))
                    begin
                        count_next = count_inc;
                        if (reached && status_reg != ST_LOST)
                        begin
                            status_next = ST_LOST;
                            alarm_next  = 1'b1;
                            lost_ev     = 1'b1;
                            sound_ev    = phase_reg;
                            stop_ev     = !phase_reg;
                        end
                    end
                    else if (is_high)
                    begin
                        count_next  = '0;
                        status_next = ST_OK;
                        if (status_reg == ST_LOST)
                        begin
                            alarm_next = 1'b0;
                            rest_ev    = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = ST_DEGRADED;
                    end
                end
            end
            KIND_TEMP:
            begin
                phase_next = temp_crit;
            end
            KIND_ACK:
            begin
                alarm_next = 1'b0;
            end
            KIND_START:
            begin
                if (!monitor_reg)
                begin
                    phase_next   = temp_crit;
                    count_next   = '0;
                    alarm_next   = 1'b0;
                    monitor_next = 1'b1;
                end
            end
            KIND_STOP:
            begin
                if (monitor_reg)
                begin
                    monitor_next = 1'b0;
                    alarm_next   = 1'b0;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_comb
    begin
        res.vent_status     = status_next;
        res.critical_phase  = phase_next;
        res.alarm_on        = alarm_next;
        res.lost_event      = lost_ev;
        res.stop_experiment = stop_ev;
        res.sound_alarm     = sound_ev;
        res.restored_event  = rest_ev;
        res.start_ok        = start_ok;
    end
    assign res_valid = in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            kind_reg <= item_kind;
            code_reg <= item_pressure_code;
            temp_reg <= item_temperature;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= ST_UNKNOWN;
            phase_reg   <= 1'b0;
            count_reg   <= '0;
            alarm_reg   <= 1'b0;
            monitor_reg <= 1'b0;
        end
        else if (advance)
        begin
            status_reg  <= status_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            alarm_reg   <= alarm_next;
            monitor_reg <= monitor_next;
        end
    end

    `VPA_ASSERT(a_lost_latches, advance && lost_ev |=> status_reg == ST_LOST && alarm_reg, "lost event did not latch status and alarm")
    `VPA_ASSERT(a_restore_clears, advance && rest_ev |=> status_reg == ST_OK && count_reg == '0 && !alarm_reg, "restore left count or alarm set")
    `VPA_ASSERT(a_idle_quiet, advance && !monitor_reg |-> !lost_ev && !rest_ev, "event raised while monitoring off")
    `VPA_ASSERT(a_mark_split, lost_ev == (stop_ev || sound_ev) && !(stop_ev && sound_ev), "lost event marking inconsistent")
    `VPA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !in_valid_reg || $past(rst_n), "input register valid out of reset")

endmodule

// ===== sv/vpa_out_stage.sv =====
// Result register between the core and the output channel.
module vpa_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  vpa_pkg::res_t in_res,
    vpa_result_if.source  result
);
    import vpa_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign in_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

    assign result.valid           = valid_reg;
    assign result.vent_status     = res_reg.vent_status;
    assign result.critical_phase  = res_reg.critical_phase;
    assign result.alarm_on        = res_reg.alarm_on;
    assign result.lost_event      = res_reg.lost_event;
    assign result.stop_experiment = res_reg.stop_experiment;
    assign result.sound_alarm     = res_reg.sound_alarm;
    assign result.restored_event  = res_reg.restored_event;
    assign result.start_ok        = res_reg.start_ok;

endmodule

// ===== sv/ventilation_pressure_alarm_unit.sv =====
// Ventilation pressure alarm: hysteresis comparator with debounce, top level.
//
// Every transfer on the item channel (a pressure sample, temperature update,
// acknowledge, start or stop) yields exactly one transfer on the result
// channel, in order. Sustained rate is one item per clock while the sink
// takes every result. The item lands in the input register at its transfer
// and moves to the result register once that register is free; the result
// is valid from there. Each item makes its update of the monitor state
// (status, phase, lost count, alarm, monitoring flag) before the next one is
// looked at. While a result waits for the sink, the input register can still
// take one more item; after that the item channel stalls until the sink takes
// the result. Configuration is written through cfg_we / cfg_index / cfg_wdata
// and must only change while no item is in flight. No clearing pass is needed
// after reset.
module ventilation_pressure_alarm_unit #(
    parameter int SAMPLE_BITS = vpa_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = vpa_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vpa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    vpa_item_if.sink                           item,
    vpa_result_if.source                       result
);
    import vpa_pkg::*;

    cfg_t cfg;
    res_t core_res;
    logic core_valid;
    logic stage_ready;

    // threshold, debounce and phase settings
    vpa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register, classification and state update; the state only
    // moves when the item leaves the input register for the result stage
    vpa_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .item_valid         (item.valid),
        .item_ready         (item.ready),
        .item_kind          (item.kind),
        .item_pressure_code (SAMPLE_BITS'(item.pressure_code)),
        .item_temperature   (item.temperature),
        .res_valid          (core_valid),
        .res_ready          (stage_ready),
        .res                (core_res)
    );

    // result register facing the sink
    vpa_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (core_valid),
        .in_ready (stage_ready),
        .in_res   (core_res),
        .result   (result)
    );

endmodule

// ===== tb/vpa_alarm_checker.sv =====
// Checker for the ventilation pressure alarm: predicts each report and compares it.
`timescale 1ns / 100ps

module vpa_alarm_checker
    import vpa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    vpa_item_if                       item_mon,
    vpa_result_if                     result_mon,
    output int                        mismatch_count,
    output int                        pending_count
);

    localparam int SHOWN_MISMATCHES = 10;

    // Threshold copies, updated from observed register writes
    logic [15:0]        ok_level;
    logic [15:0]        lost_level;
    logic [7:0]         debounce;
    logic signed [15:0] crit_level;

    // Monitor state
    status_t            status_q;
    logic               phase_q;
    logic               alarm_q;
    logic               monitoring_q;
    logic [7:0]         lost_count_q;

    res_t               predicted_reports[$];

    function automatic status_t grade_sample(input logic [15:0] code, input status_t current);
        if (code < lost_level)
            return ST_LOST;
        if (code >= ok_level)
            return ST_OK;
        return (current == ST_LOST) ? ST_LOST : ST_DEGRADED;
    endfunction

    // Applies one event to the monitor state and returns the report it gives.
    function res_t advance_monitor(input logic [2:0] kind, input logic [15:0] code,
                                   input logic signed [15:0] temp);
        res_t       rep;
        status_t    reading;
        logic [7:0] limit;
        rep = '0;
        case (kind)
            KIND_SAMPLE:
            begin
                rep.start_ok = (grade_sample(code, ST_UNKNOWN) == ST_OK);
                if (monitoring_q)
                begin
                    reading = grade_sample(code, status_q);
                    if (reading == ST_LOST)
                    begin
                        limit = (debounce == '0) ? 8'd1 : debounce;
                        if (lost_count_q != '1)
                            lost_count_q = lost_count_q + 8'd1;
                        if (lost_count_q >= limit && status_q != ST_LOST)
                        begin
                            status_q = ST_LOST;
                            alarm_q = 1'b1;
                            rep.lost_event = 1'b1;
                            if (phase_q)
                                rep.sound_alarm = 1'b1;
                            else
                                rep.stop_experiment = 1'b1;
                        end
                    end
                    else if (reading == ST_OK)
                    begin
                        lost_count_q = '0;
                        if (status_q == ST_LOST)
                        begin
                            alarm_q = 1'b0;
                            rep.restored_event = 1'b1;
                        end
                        status_q = ST_OK;
                    end
                    else
                    begin
                        status_q = reading;
                    end
                end
            end
            KIND_TEMP:
                phase_q = (temp >= crit_level);
            KIND_ACK:
                alarm_q = 1'b0;
            KIND_START:
            begin
                if (!monitoring_q)
                begin
                    phase_q = (temp >= crit_level);
                    lost_count_q = '0;
                    alarm_q = 1'b0;
                    monitoring_q = 1'b1;
                end
            end
            KIND_STOP:
            begin
                if (monitoring_q)
                begin
                    monitoring_q = 1'b0;
                    alarm_q = 1'b0;
                end
            end
            default:
                ;
        endcase
        rep.vent_status = status_q;
        rep.critical_phase = phase_q;
        rep.alarm_on = alarm_q;
        return rep;
    endfunction

    function automatic string describe(input res_t r);
        return $sformatf("status=%0d crit=%0b alarm=%0b lost=%0b stop=%0b sound=%0b rest=%0b ok=%0b",
                         r.vent_status, r.critical_phase, r.alarm_on, r.lost_event,
                         r.stop_experiment, r.sound_alarm, r.restored_event, r.start_ok);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display("[%0t] report mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t wanted;
        res_t seen;
        if (!rst_n)
        begin
            ok_level       = OK_MIN_RESET;
            lost_level     = LOST_LVL_RESET;
            debounce       = DEBOUNCE_RESET;
            crit_level     = CRIT_TEMP_RESET;
            status_q       = ST_UNKNOWN;
            phase_q        = 1'b0;
            alarm_q        = 1'b0;
            monitoring_q   = 1'b0;
            lost_count_q   = '0;
            predicted_reports.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            // Predict before retiring, so ordering holds at any latency
            if (item_mon.valid && item_mon.ready)
                predicted_reports.push_back(advance_monitor(item_mon.kind,
                                                            item_mon.pressure_code,
                                                            item_mon.temperature));

            if (result_mon.valid && result_mon.ready)
            begin
                seen.vent_status     = status_t'(result_mon.vent_status);
                seen.critical_phase  = result_mon.critical_phase;
                seen.alarm_on        = result_mon.alarm_on;
                seen.lost_event      = result_mon.lost_event;
                seen.stop_experiment = result_mon.stop_experiment;
                seen.sound_alarm     = result_mon.sound_alarm;
                seen.restored_event  = result_mon.restored_event;
                seen.start_ok        = result_mon.start_ok;
                if (predicted_reports.size() == 0)
                begin
                    note_mismatch({"unexpected transfer: ", describe(seen)});
                end
                else
                begin
                    wanted = predicted_reports.pop_front();
                    if (seen.vent_status     !== wanted.vent_status     ||
                        seen.critical_phase  !== wanted.critical_phase  ||
                        seen.alarm_on        !== wanted.alarm_on        ||
                        seen.lost_event      !== wanted.lost_event      ||
                        seen.stop_experiment !== wanted.stop_experiment ||
                        seen.sound_alarm     !== wanted.sound_alarm     ||
                        seen.restored_event  !== wanted.restored_event  ||
                        seen.start_ok        !== wanted.start_ok)
                        note_mismatch({"exp ", describe(wanted), " / got ", describe(seen)});
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OK_MIN:    ok_level   = cfg_wdata;
                    CFG_LOST_LVL:  lost_level = cfg_wdata;
                    CFG_DEBOUNCE:  debounce   = cfg_wdata[7:0];
                    CFG_CRIT_TEMP: crit_level = signed'(cfg_wdata);
                    default:       ;
                endcase
            end

            pending_count = predicted_reports.size();
        end
    end

endmodule

// ===== tb/ventilation_pressure_alarm_unit_tb.sv =====
// Testbench top for the ventilation pressure alarm unit: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module ventilation_pressure_alarm_unit_tb;
    import vpa_pkg::*;

    // Kinds beyond stop: the block must treat them as inert events
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // Sample code bands relative to the current thresholds
    localparam int BAND_LOST = 0;
    localparam int BAND_MID  = 1;
    localparam int BAND_OK   = 2;
    localparam int BAND_EDGE = 3;
    localparam int BAND_ANY  = 4;

    // Watchdog: cycles without any transfer before the run is abandoned.
    // The worst stall is a run of refusals at 79 % idle, far below this.
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles after the last report; the block is two stages deep
    localparam int END_SETTLE  = 10;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    int mismatch_count;
    int pending_count;
    int items_sent = 0;
    int tx_idle_pct = 28;
    int rx_idle_pct = 79;

    // Stimulus-side copy of the thresholds, only used to aim sample codes, temperatures and lost runs
    logic [15:0]        cur_ok   = OK_MIN_RESET;
    logic [15:0]        cur_lost = LOST_LVL_RESET;
    logic [7:0]         cur_deb  = DEBOUNCE_RESET;
    logic signed [15:0] cur_crit = CRIT_TEMP_RESET;

    vpa_item_if   item_ch ();
    vpa_result_if result_ch ();

    ventilation_pressure_alarm_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch.sink),
        .result    (result_ch.source)
    );

    vpa_alarm_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item_mon       (item_ch),
        .result_mon     (result_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result sink: ready is redrawn at every falling edge
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: any transfer on either channel resets the count
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("ventilation_pressure_alarm_unit_tb: FAIL");
        $finish;
    end

    // One event transfer. Gaps are inserted before valid rises; once valid is
    // up it stays up until the transfer, as the handshake requires.
    task automatic send_event(input logic [2:0] kind, input logic [15:0] code,
                              input logic signed [15:0] temp);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= kind;
        item_ch.pressure_code <= code;
        item_ch.temperature   <= temp;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    // Sender holds off until every outstanding report has been seen
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        wait (pending_count == 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Thresholds only change with the pipeline empty
    task automatic set_config(input logic [15:0] ok_min, input logic [15:0] lost_lvl,
                              input logic [7:0] deb, input logic signed [15:0] crit);
        drain();
        write_reg(CFG_OK_MIN, ok_min);
        write_reg(CFG_LOST_LVL, lost_lvl);
        write_reg(CFG_DEBOUNCE, {8'd0, deb});
        write_reg(CFG_CRIT_TEMP, crit);
        cur_ok   = ok_min;
        cur_lost = lost_lvl;
        cur_deb  = deb;
        cur_crit = crit;
    endtask

    // Sample code aimed at a band; an empty band falls back to any code
    function automatic logic [15:0] pick_code(input int band);
        case (band)
            BAND_LOST:
                if (cur_lost != 16'd0)
                    return 16'($urandom_range(0, cur_lost - 1));
            BAND_MID:
                if (cur_lost < cur_ok)
                    return 16'($urandom_range(cur_lost, cur_ok - 1));
            BAND_OK:
                return 16'($urandom_range(cur_ok, 16'hFFFF));
            BAND_EDGE:
                case ($urandom_range(0, 3))
                    0:       return cur_lost - 16'd1;
                    1:       return cur_lost;
                    2:       return cur_ok - 16'd1;
                    default: return cur_ok;
                endcase
            default:
                ;
        endcase
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Half the temperatures sit on the critical boundary, the rest anywhere
    function automatic logic signed [15:0] pick_temp();
        int t;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom);
        t = int'(cur_crit) + int'($urandom_range(0, 6)) - 3;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t[15:0];
    endfunction

    // A monitoring session: start, bursts of readings and housekeeping, stop.
    // Lost runs are sized around the debounce limit so the alarm really trips.
    task automatic run_session();
        int deb;
        send_event(KIND_START, 16'($urandom), pick_temp());
        deb = (cur_deb == 8'd0) ? 1 : cur_deb;
        if (deb > 12)
            deb = 12;
        repeat ($urandom_range(2, 8))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    repeat ($urandom_range(1, deb + 2))
                        send_event(KIND_SAMPLE, pick_code(BAND_LOST), 16'($urandom));
                3:
                    repeat ($urandom_range(1, 4))
                        send_event(KIND_SAMPLE, pick_code(BAND_MID), 16'($urandom));
                4, 5:
                    repeat ($urandom_range(1, 3))
                        send_event(KIND_SAMPLE, pick_code(BAND_OK), 16'($urandom));
                6:
                    repeat ($urandom_range(1, 4))
                        send_event(KIND_SAMPLE, pick_code($urandom_range(BAND_LOST, BAND_ANY)),
                                   16'($urandom));
                7:
                    send_event(KIND_TEMP, 16'($urandom), pick_temp());
                8:
                    send_event(KIND_ACK, 16'($urandom), 16'($urandom));
                default:
                    // A second start must be ignored, as must a spare kind
                    if ($urandom_range(0, 1) == 0)
                        send_event(KIND_START, 16'($urandom), pick_temp());
                    else
                        send_event(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                                   16'($urandom), 16'($urandom));
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            send_event(KIND_STOP, 16'($urandom), 16'($urandom));
    endtask

    // Mostly sessions; some stray events of any kind; an occasional full pause
    task automatic random_phase(input int quota);
        int goal;
        goal = items_sent + quota;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 29) == 0)
                drain();
            if ($urandom_range(0, 4) == 0)
                send_event(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
            else
                run_session();
        end
    endtask

    initial
    begin
        logic [15:0] rnd_ok;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_OK_MIN;
        cfg_wdata             = '0;
        item_ch.valid         = 1'b0;
        item_ch.kind          = KIND_SAMPLE;
        item_ch.pressure_code = '0;
        item_ch.temperature   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk at the reset thresholds (ok 40000, lost 20000,
        // debounce 3, critical 80.0 degrees)
        send_event(KIND_SAMPLE, 16'hFFFF, 16'sd0);     // monitoring off: start_ok only
        send_event(KIND_SAMPLE, 16'd0, 16'sd0);
        send_event(KIND_STOP, 16'd0, 16'sd0);          // stop while idle is ignored
        send_event(KIND_TEMP, 16'd0, 16'sh7FFF);       // phase follows even when idle
        send_event(KIND_TEMP, 16'd0, 16'sh8000);
        send_event(KIND_START, 16'd0, 16'sd799);       // safe phase
        send_event(KIND_START, 16'd0, 16'sd900);       // already monitoring: ignored
        send_event(KIND_SAMPLE, 16'd45000, 16'sd0);    // ok
        send_event(KIND_SAMPLE, 16'd30000, 16'sd0);    // middle band -> degraded
        send_event(KIND_SAMPLE, 16'd0, 16'sd0);        // lost readings below debounce
        send_event(KIND_SAMPLE, 16'd19999, 16'sd0);
        send_event(KIND_SAMPLE, 16'd0, 16'sd0);        // third: lost, stop experiment
        send_event(KIND_SAMPLE, 16'd30000, 16'sd0);    // middle band keeps lost
        send_event(KIND_SAMPLE, 16'd40000, 16'sd0);    // restored
        send_event(KIND_TEMP, 16'd0, 16'sd800);        // critical at the threshold
        repeat (3)
            send_event(KIND_SAMPLE, 16'd100, 16'sd0);  // lost in critical: sound alarm
        send_event(KIND_ACK, 16'd0, 16'sd0);
        send_event(KIND_SAMPLE, 16'hFFFF, 16'sd0);
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_event(3'(k), 16'hFFFF, 16'sh7FFF);
        send_event(KIND_STOP, 16'd0, 16'sd0);

        // Sender fairly busy, sink mostly stalled
        set_config(16'd40000, 16'd20000, 8'd3, 16'sd800);
        random_phase(20);
        set_config(16'hFFFF, 16'd0, 8'd1, 16'sh8000);  // nothing lost, always critical
        random_phase(15);

        // Sender mostly idle, sink fairly free
        tx_idle_pct = 79;
        rx_idle_pct = 28;
        set_config(16'd0, 16'hFFFF, 8'd0, 16'sh7FFF);  // crossed thresholds, debounce zero
        random_phase(15);
        set_config(16'd30000, 16'd10000, 8'd255, 16'sd0);
        // Lost count runs into saturation; the limit of 255 is reached there
        send_event(KIND_START, 16'd0, 16'sd0);
        repeat (260)
            send_event(KIND_SAMPLE, pick_code(BAND_LOST), 16'($urandom));
        send_event(KIND_SAMPLE, 16'd30000, 16'sd0);
        send_event(KIND_SAMPLE, 16'hFFFF, 16'sd0);
        send_event(KIND_STOP, 16'd0, 16'sd0);
        random_phase(10);

        // Both sides flat out
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rnd_ok = 16'($urandom_range(1, 16'hFFFF));
        set_config(rnd_ok, 16'($urandom_range(0, rnd_ok)), 8'($urandom_range(0, 8)),
                   16'($urandom));
        random_phase(15);
        set_config(16'd50000, 16'd30000, 8'd5, -16'sd100);
        random_phase(20);

        drain();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("ventilation_pressure_alarm_unit_tb: PASS");
        else
            $display("ventilation_pressure_alarm_unit_tb: FAIL");
        $finish;
    end

endmodule
